// ===== src/mht_pkg.sv =====
// ----------------------------------------------------------------------------
// mht_pkg
// Shared codes and character constants for the manifest header tokenizer.
// ----------------------------------------------------------------------------
package mht_pkg;

    localparam logic [7:0] CHAR_COLON = 8'h3A;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_NUL   = 8'h00;

    localparam logic REQ_BYTE = 1'b0;
    localparam logic REQ_END  = 1'b1;

    typedef enum logic [2:0] {
        ROLE_DROPPED  = 3'd0,
        ROLE_NAME     = 3'd1,
        ROLE_NAME_END = 3'd2,
        ROLE_VALUE    = 3'd3,
        ROLE_IGNORED  = 3'd4
    } role_t;

    typedef enum logic [1:0] {
        ERR_NONE     = 2'd0,
        ERR_NO_SPACE = 2'd1,
        ERR_NUL      = 2'd2,
        ERR_EOB      = 2'd3
    } err_t;

    typedef struct packed {
        err_t       error_code;
        logic       section_end;
        logic       header_kept;
        logic       header_end;
        logic [7:0] byte_out;
    } result_t;

endpackage

// ===== src/manifest_header_tokenizer_core.sv =====
// ----------------------------------------------------------------------------
// manifest_header_tokenizer_core
// Tags manifest bytes as name, name end, value, dropped or ignored, and flags
// header, section and buffer ends.
// ----------------------------------------------------------------------------
// Input channel s_*: one word per manifest byte (s_tuser = 0) or an
// end-of-buffer marker (s_tuser = 1, s_tdata ignored).
// Output channel m_*: exactly one word per input word, in order. m_tuser
// carries the byte role, m_tdata the echoed byte, header/section flags and
// the error code, m_tlast marks the word produced by an end marker.
// Path: input register, then result register. Throughput: one word per cycle
// while the receiver takes results; the tokenizer state is updated as an
// item moves from the input register to the result register, so this
// state update sets the rate.
// Reset: the parser returns to reading a name with no breaks counted, no
// pending carriage return and no error; both registers are empty.
// Receiver stall: the result register holds its word, the input register
// keeps accepting until it is full, then s_tready drops.
// ----------------------------------------------------------------------------
module manifest_header_tokenizer_core
    import mht_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tuser,   // [0] req_type
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [7:0] byte_out, [8] header_end,
                                   // [9] header_kept, [10] section_end,
                                   // [12:11] error_code, [15:13] zero
    output logic [2:0]  m_tuser,   // [2:0] byte_role
    output logic        m_tlast    // stream_end
);

    typedef enum logic [1:0] {
        PH_NAME  = 2'd0,
        PH_SPACE = 2'd1,
        PH_VALUE = 2'd2
    } phase_t;

    logic       in_valid_reg;
    logic       in_req_reg;
    logic [7:0] in_byte_reg;

    phase_t     phase_reg, phase_next;
    logic [1:0] breaks_reg, breaks_next;
    logic       cr_reg, cr_next;
    logic       failed_reg, failed_next;

    logic       out_valid_reg;
    role_t      role_reg, role_next;
    result_t    res_reg, res_next;
    logic       last_reg, last_next;

    logic       advance;
    logic [1:0] breaks_bump;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    assign breaks_bump = (breaks_reg == 2'd3) ? 2'd3 : breaks_reg + 2'd1;

    always_comb
    begin
        phase_next  = phase_reg;
        breaks_next = breaks_reg;
        cr_next     = cr_reg;
        failed_next = failed_reg;
        role_next   = ROLE_DROPPED;
        res_next    = '0;
        last_next   = 1'b0;

        if (in_req_reg == REQ_END)
        begin
            last_next = 1'b1;
            if (!failed_reg)
            begin
                if (phase_reg == PH_VALUE)
                begin
                    res_next.header_end  = 1'b1;
                    res_next.header_kept = (breaks_reg != 2'd0);
                    res_next.section_end = (breaks_reg > 2'd1);
                end
                else if (phase_reg == PH_SPACE)
                begin
                    res_next.error_code = ERR_EOB;
                end
            end
            phase_next  = PH_NAME;
            breaks_next = 2'd0;
            cr_next     = 1'b0;
            failed_next = 1'b0;
        end
        else if (failed_reg)
        begin
            role_next = ROLE_IGNORED;
        end
        else
        begin
            unique case (phase_reg)
                PH_SPACE:
                begin
                    if (in_byte_reg == CHAR_SPACE)
                    begin
                        phase_next  = PH_VALUE;
                        breaks_next = 2'd0;
                        cr_next     = 1'b0;
                    end
                    else
                    begin
                        res_next.error_code = ERR_NO_SPACE;
                        failed_next         = 1'b1;
                    end
                end
                PH_VALUE:
                begin
                    if (in_byte_reg == CHAR_NUL)
                    begin
                        res_next.error_code = ERR_NUL;
                        failed_next         = 1'b1;
                    end
                    else if (in_byte_reg == CHAR_LF)
                    begin
                        if (cr_reg)
                            cr_next = 1'b0;
                        else
                            breaks_next = breaks_bump;
                    end
                    else if (in_byte_reg == CHAR_CR)
                    begin
                        cr_next     = 1'b1;
                        breaks_next = breaks_bump;
                    end
                    else if (in_byte_reg == CHAR_SPACE && breaks_reg == 2'd1)
                    begin
                        breaks_next = 2'd0;
                    end
                    else if (breaks_reg != 2'd0)
                    begin
                        res_next.header_end  = 1'b1;
                        res_next.header_kept = 1'b1;
                        res_next.section_end = (breaks_reg > 2'd1);
                        breaks_next          = 2'd0;
                        if (in_byte_reg == CHAR_COLON)
                        begin
                            role_next  = ROLE_NAME_END;
                            phase_next = PH_SPACE;
                        end
                        else
                        begin
                            role_next         = ROLE_NAME;
                            res_next.byte_out = in_byte_reg;
                            phase_next        = PH_NAME;
                        end
                    end
                    else
                    begin
                        role_next         = ROLE_VALUE;
                        res_next.byte_out = in_byte_reg;
                    end
                end
                default:
                begin
                    if (in_byte_reg == CHAR_COLON)
                    begin
                        role_next  = ROLE_NAME_END;
                        phase_next = PH_SPACE;
                    end
                    else
                    begin
                        role_next         = ROLE_NAME;
                        res_next.byte_out = in_byte_reg;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            phase_reg     <= PH_NAME;
            breaks_reg    <= 2'd0;
            cr_reg        <= 1'b0;
            failed_reg    <= 1'b0;
        end
        else
        begin
            if (s_tready)
                in_valid_reg <= s_tvalid;
            if (advance)
            begin
                out_valid_reg <= 1'b1;
                phase_reg     <= phase_next;
                breaks_reg    <= breaks_next;
                cr_reg        <= cr_next;
                failed_reg    <= failed_next;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_req_reg  <= s_tuser;
            in_byte_reg <= s_tdata;
        end
        if (advance)
        begin
            role_reg <= role_next;
            res_reg  <= res_next;
            last_reg <= last_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000, res_reg};
    assign m_tuser  = role_reg;
    assign m_tlast  = last_reg;

    a_kept_needs_end : assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (res_reg.header_kept || res_reg.section_end) |-> res_reg.header_end)
        else $error("header_kept or section_end without header_end");

    a_error_dropped : assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && res_reg.error_code != ERR_NONE |-> role_reg == ROLE_DROPPED)
        else $error("error reported on a byte that is not dropped");

    a_end_resets : assert property (@(posedge clk) disable iff (!rst_n)
        advance && in_req_reg == REQ_END |=> phase_reg == PH_NAME && breaks_reg == 2'd0
            && !cr_reg && !failed_reg)
        else $error("end marker did not return parser to start");

    a_ignored_quiet : assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && role_reg == ROLE_IGNORED |-> res_reg == '0 && !m_tlast)
        else $error("ignored byte carries data");

    a_value_clears_cr : assert property (@(posedge clk) disable iff (!rst_n)
        advance && !failed_reg && in_req_reg == REQ_BYTE && phase_reg == PH_SPACE
            && in_byte_reg == CHAR_SPACE |=> !cr_reg && breaks_reg == 2'd0)
        else $error("value start left stale break state");

endmodule
